### sv/dtd_pkg.sv
// Package for the task dispatcher: payload structs, codes and defaults.
// Used by every module of the dispatcher; depends on nothing.
`default_nettype none
package dtd_pkg;
	localparam int DEF_PENDING_DEPTH = 16;
	localparam int DEF_MAX_WORKERS = 8;
	localparam int DEF_MAX_DEPS = 4;
	localparam int DEP_FIELDS = 4;
	localparam int ID_W = 16;

	localparam logic [2:0] MODE_SUBMIT = 3'd0;
	localparam logic [2:0] MODE_DISPATCH = 3'd1;
	localparam logic [2:0] MODE_COMPLETE = 3'd2;
	localparam logic [2:0] MODE_QUERY = 3'd3;
	localparam logic [2:0] MODE_SHUTDOWN = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_STOPPED = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_NONE = 3'd3;
	localparam logic [2:0] ST_IDLE = 3'd4;
	localparam logic [2:0] ST_EXIT = 3'd5;
	localparam logic [2:0] ST_BADW = 3'd6;

	localparam logic [3:0] AW_RESET = 4'd4;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] job_tag;
		logic [2:0]  dep_count;
		logic [15:0] dep_id_0;
		logic [15:0] dep_id_1;
		logic [15:0] dep_id_2;
		logic [15:0] dep_id_3;
		logic [2:0]  worker_index;
		logic [15:0] target_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] task_id;
		logic [15:0] task_tag;
		logic [2:0]  worker_echo;
		logic        running_flag;
		logic        pending_flag;
	} out_item_t;
endpackage
`default_nettype wire

### sv/dtd_front.sv
// Front end: takes input items, drops unused modes, saturates the dependency count, queues them.
// Depends on dtd_pkg.
`default_nettype none
module dtd_front #(
	parameter int QDEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire dtd_pkg::in_item_t in_item,
	output logic                  q_valid,
	input  wire logic             q_ready,
	output dtd_pkg::in_item_t     q_item
);
	import dtd_pkg::*;
	localparam int QW = $clog2(QDEPTH);

	in_item_t  mem_q [QDEPTH];
	logic [QW-1:0] wp_q, rp_q;
	logic [QW:0]   cnt_q;
	logic push, pop;
	in_item_t clean;

	always_comb begin
		clean = in_item;
		if (clean.dep_count > 3'(DEP_FIELDS))
			clean.dep_count = 3'(DEP_FIELDS);
	end

	assign in_ready = (cnt_q != (QW+1)'(QDEPTH));
	assign push = in_valid && in_ready && (in_item.mode <= MODE_SHUTDOWN);
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= clean;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == QW'(QDEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == QW'(QDEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

### sv/dtd_back.sv
// Back end: pending queue and running table, scans one pending entry a cycle.
// Depends on dtd_pkg.
`default_nettype none
module dtd_back #(
	parameter int PENDING_DEPTH = dtd_pkg::DEF_PENDING_DEPTH,
	parameter int MAX_WORKERS = dtd_pkg::DEF_MAX_WORKERS,
	parameter int MAX_DEPS = dtd_pkg::DEF_MAX_DEPS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [3:0]        active_workers,
	input  wire logic              q_valid,
	output logic                   q_ready,
	input  wire dtd_pkg::in_item_t q_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dtd_pkg::out_item_t     out_item
);
	import dtd_pkg::*;
	localparam int PW = $clog2(PENDING_DEPTH);
	localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int NDEP = (MAX_DEPS < DEP_FIELDS) ? MAX_DEPS : DEP_FIELDS;
	localparam int DW = $clog2(NDEP + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

	state_t state_q;
	logic [PENDING_DEPTH-1:0] pv_q;
	logic [ID_W-1:0] pid_q [PENDING_DEPTH];
	logic [15:0]     ptag_q [PENDING_DEPTH];
	logic [DW-1:0]   pdc_q [PENDING_DEPTH];
	logic [ID_W-1:0] pdep_q [PENDING_DEPTH][NDEP];
	logic [MAX_WORKERS-1:0] rv_q;
	logic [ID_W-1:0] rid_q [MAX_WORKERS];
	logic [ID_W-1:0] next_id_q;
	logic term_q, stop_q;
	logic [PW:0] pcnt_q;
	logic [PW-1:0] scan_q;
	in_item_t cur_q;
	out_item_t res_q;

	// Per-cycle dependency check of the entry under scan
	logic entry_ok;
	logic [ID_W-1:0] dep_id [DEP_FIELDS];
	logic [WW-1:0] wsel;
	logic [4:0] aw_eff;
	logic in_run, in_pend;
	logic bad_w, to_scan;
	out_item_t res_acc;

	assign dep_id[0] = q_item.dep_id_0;
	assign dep_id[1] = q_item.dep_id_1;
	assign dep_id[2] = q_item.dep_id_2;
	assign dep_id[3] = q_item.dep_id_3;
	assign wsel = WW'(cur_q.worker_index);

	always_comb begin
		aw_eff = {1'b0, active_workers};
		if (aw_eff == 5'd0) aw_eff = 5'd1;
		if (aw_eff > 5'(MAX_WORKERS)) aw_eff = 5'(MAX_WORKERS);
	end

	always_comb begin
		entry_ok = 1'b1;
		for (int d = 0; d < NDEP; d++) begin
			if (DW'(d) < pdc_q[scan_q]) begin
				for (int r = 0; r < MAX_WORKERS; r++)
					if (rv_q[r] && rid_q[r] == pdep_q[scan_q][d]) entry_ok = 1'b0;
				for (int p = 0; p < PENDING_DEPTH; p++)
					if (pv_q[p] && pid_q[p] == pdep_q[scan_q][d]) entry_ok = 1'b0;
			end
		end
	end

	always_comb begin
		in_run = 1'b0;
		in_pend = 1'b0;
		for (int r = 0; r < MAX_WORKERS; r++)
			if (rv_q[r] && rid_q[r] == cur_q.target_id) in_run = 1'b1;
		for (int p = 0; p < PENDING_DEPTH; p++)
			if (pv_q[p] && pid_q[p] == cur_q.target_id) in_pend = 1'b1;
	end

	// Result of the item at the head of the queue, as far as it is known on accept
	assign bad_w = ({2'b0, q_item.worker_index} >= aw_eff) || rv_q[WW'(q_item.worker_index)];
	assign to_scan = (q_item.mode == MODE_QUERY)
		|| (q_item.mode == MODE_DISPATCH && !bad_w && pcnt_q != '0);

	always_comb begin
		res_acc = '0;
		case (q_item.mode)
			MODE_SUBMIT: begin
				if (stop_q)
					res_acc.status = ST_STOPPED;
				else if (pcnt_q == (PW+1)'(PENDING_DEPTH))
					res_acc.status = ST_FULL;
				else
					res_acc.task_id = next_id_q;
			end
			MODE_DISPATCH: begin
				res_acc.worker_echo = q_item.worker_index;
				if (bad_w)
					res_acc.status = ST_BADW;
				else if (pcnt_q == '0)
					res_acc.status = term_q ? ST_EXIT : ST_IDLE;
			end
			MODE_COMPLETE, MODE_QUERY: res_acc.task_id = q_item.target_id;
			default: ;
		endcase
	end

	assign q_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_item = res_q;

	// Pending storage: append and compacting removal
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid && q_item.mode == MODE_SUBMIT && !stop_q
		    && pcnt_q != (PW+1)'(PENDING_DEPTH)) begin
			pid_q[pcnt_q[PW-1:0]] <= next_id_q;
			ptag_q[pcnt_q[PW-1:0]] <= q_item.job_tag;
			pdc_q[pcnt_q[PW-1:0]] <= DW'(q_item.dep_count > 3'(NDEP) ? 3'(NDEP)
			                                                          : q_item.dep_count);
			for (int d = 0; d < NDEP; d++)
				pdep_q[pcnt_q[PW-1:0]][d] <= (3'(d) < q_item.dep_count) ? dep_id[d] : '0;
		end else if (state_q == S_SCAN && cur_q.mode == MODE_DISPATCH && entry_ok) begin
			for (int i = 0; i < PENDING_DEPTH - 1; i++)
				if (PW'(i) >= scan_q) begin
					pid_q[i] <= pid_q[i+1];
					ptag_q[i] <= ptag_q[i+1];
					pdc_q[i] <= pdc_q[i+1];
					pdep_q[i] <= pdep_q[i+1];
				end
			rid_q[wsel] <= pid_q[scan_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pv_q <= '0;
			rv_q <= '0;
			next_id_q <= '0;
			term_q <= 1'b0;
			stop_q <= 1'b0;
			pcnt_q <= '0;
			scan_q <= '0;
			cur_q <= '0;
			res_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q <= q_item;
						res_q <= res_acc;
						scan_q <= '0;
						state_q <= to_scan ? S_SCAN : S_OUT;
						case (q_item.mode)
							MODE_SUBMIT: begin
								if (!stop_q && pcnt_q != (PW+1)'(PENDING_DEPTH)) begin
									pv_q[pcnt_q[PW-1:0]] <= 1'b1;
									pcnt_q <= pcnt_q + 1'b1;
									next_id_q <= next_id_q + 1'b1;
								end
							end
							MODE_COMPLETE: begin
								for (int r = 0; r < MAX_WORKERS; r++)
									if (rid_q[r] == q_item.target_id) rv_q[r] <= 1'b0;
							end
							MODE_SHUTDOWN: begin
								term_q <= 1'b1;
								if (pcnt_q == '0 && rv_q == '0) stop_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (cur_q.mode == MODE_QUERY) begin
						res_q.running_flag <= in_run;
						res_q.pending_flag <= in_pend;
						state_q <= S_OUT;
					end else if (entry_ok) begin
						res_q.task_id <= pid_q[scan_q];
						res_q.task_tag <= ptag_q[scan_q];
						rv_q[wsel] <= 1'b1;
						pv_q <= pv_q >> 1 | (pv_q & ((PENDING_DEPTH)'(1) << scan_q) - 1'b1);
						pcnt_q <= pcnt_q - 1'b1;
						state_q <= S_OUT;
					end else if ((PW+1)'(scan_q) + 1'b1 == pcnt_q) begin
						res_q.status <= ST_NONE;
						state_q <= S_OUT;
					end else
						scan_q <= scan_q + 1'b1;
				end
				S_OUT: begin
					// Stop check once the item has settled the tables
					if (term_q && pcnt_q == '0 && rv_q == '0) stop_q <= 1'b1;
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/dependency_aware_task_dispatcher_core.sv
// Dependency-aware task dispatcher. Each item (submit, dispatch request, complete,
// query, shutdown) gives one result item; modes 5 to 7 are dropped with no result.
// An accepted item reaches the back end through a two-entry queue. There submit,
// complete and shutdown go from the idle state straight to the output state, a query
// passes through the scan state first; a dispatch request refused at once (bad worker,
// empty queue) goes straight to output, otherwise it scans the pending queue one entry
// a cycle, oldest first. Depends on dtd_pkg, dtd_front and dtd_back.
`default_nettype none
module dependency_aware_task_dispatcher_core #(
	parameter int PENDING_DEPTH = dtd_pkg::DEF_PENDING_DEPTH,
	parameter int MAX_WORKERS = dtd_pkg::DEF_MAX_WORKERS,
	parameter int MAX_DEPS = dtd_pkg::DEF_MAX_DEPS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire dtd_pkg::in_item_t in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dtd_pkg::out_item_t     out_item,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [3:0]        cfg_data
);
	import dtd_pkg::*;

	logic [3:0] aw_q;
	logic q_valid, q_ready;
	in_item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			aw_q <= AW_RESET;
		else if (cfg_valid)
			aw_q <= cfg_data;
	end

	dtd_front #(.QDEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	dtd_back #(
		.PENDING_DEPTH(PENDING_DEPTH), .MAX_WORKERS(MAX_WORKERS), .MAX_DEPS(MAX_DEPS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .active_workers(aw_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule
`default_nettype wire
